@@ hw/rtl/ifp_pkg.sv @@
// Shared types and constants of the integer field parser.
// No dependencies; every other file of the block but ifp_if imports this package.
package ifp_pkg;

  // Base selection codes
  localparam logic [1:0] MODE_DEC  = 2'd0;
  localparam logic [1:0] MODE_OCT  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_AUTO = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [1:0] ST_END_EARLY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_MODE  = 2'd0;
  localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_STORE_SIZE = 2'd2;

  // Store size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // Character codes
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOWER_BIT = 8'h20;
  localparam logic [7:0] CH_LC_A      = 8'h61;
  localparam logic [7:0] CH_LC_F      = 8'h66;
  localparam logic [7:0] CH_LC_X      = 8'h78;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_PREFIX,
    PH_AFTER0,
    PH_DIGITS
  } phase_t;

  // One classified item as it travels from the front to the back
  typedef struct packed {
    logic       eoi;
    logic       is_ws;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [1:0]  base_mode;
    logic [15:0] max_width;
    logic [1:0]  store_size;
  } cfg_t;

endpackage

@@ hw/rtl/ifp_if.sv @@
// Handshake channels of the integer field parser: characters in, results out,
// and the configuration write channel. No dependencies.
interface ifp_char_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;

  modport source (output valid, cmd, char_code, input ready);
  modport sink   (input valid, cmd, char_code, output ready);
endinterface

interface ifp_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;
  logic        stop_char_kept;

  modport source (output valid, value, status, stop_char_kept, input ready);
  modport sink   (input valid, value, status, stop_char_kept, output ready);
endinterface

interface ifp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ifp_front.sv @@
// Front end: accepts characters and classifies them for the parser back end.
// Depends on ifp_pkg and the ifp_char_if interface.
module ifp_front import ifp_pkg::*; (
  ifp_char_if.sink    chars,
  input  logic        q_ready,
  output logic        q_push,
  output char_class_t q_entry
);

  logic [7:0] c;
  logic [7:0] lc;

  assign c  = chars.char_code;
  assign lc = c | CH_LOWER_BIT;

  assign chars.ready = q_ready;
  assign q_push      = chars.valid && q_ready;

  always_comb begin
    q_entry = '0;
    if (chars.cmd) begin
      // end of input carries no character class at all
      q_entry.eoi = 1'b1;
    end else begin
      q_entry.is_ws    = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
      q_entry.is_minus = (c == CH_MINUS);
      q_entry.is_plus  = (c == CH_PLUS);
      q_entry.is_zero  = (c == CH_ZERO);
      q_entry.is_x     = (lc == CH_LC_X);
      if (c inside {[CH_ZERO:CH_NINE]}) begin
        q_entry.is_hex = 1'b1;
        q_entry.digit  = 4'(c - CH_ZERO);
      end else if (lc inside {[CH_LC_A:CH_LC_F]}) begin
        q_entry.is_hex = 1'b1;
        q_entry.digit  = 4'(lc - CH_LC_A + 8'd10);
      end
    end
  end

endmodule

@@ hw/rtl/ifp_queue.sv @@
// Two-entry queue of classified items between front and back end.
// Depends on ifp_pkg.
module ifp_queue import ifp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  char_class_t push_entry,
  output logic        push_ready,
  input  logic        pop,
  output logic        pop_valid,
  output char_class_t pop_entry
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  char_class_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

@@ hw/rtl/ifp_back.sv @@
// Back end: field state machine, digit accumulation and the result register.
// Depends on ifp_pkg and the ifp_result_if interface.
module ifp_back import ifp_pkg::*; #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  char_class_t   q_entry,
  output logic          q_pop,
  ifp_result_if.source  results
);

  localparam logic [31:0] WIDTH_CAP = 32'((64'd1 << WIDTH_BITS) - 64'd1);

  phase_t                phase, phase_next;
  logic [WIDTH_BITS-1:0] width_left, width_left_next;
  logic [63:0]           accum, accum_next;
  logic                  negative, negative_next;
  logic                  matched, matched_next;
  logic [1:0]            active_base, active_base_next;

  // state after this item, before any clearing at the end of a field
  phase_t                field_phase;
  logic [WIDTH_BITS-1:0] field_width;
  logic [63:0]           field_accum;
  logic                  field_neg;
  logic                  field_matched;
  logic [1:0]            field_base;

  logic                  step;
  logic                  cont;
  logic                  taken;
  logic                  done;
  logic                  width_hit;
  logic                  digit_ok;
  logic [63:0]           accum_upd;
  logic [WIDTH_BITS-1:0] width_load;

  logic                  emit;
  logic [1:0]            emit_status;
  logic                  emit_kept;
  logic [63:0]           signed_value;
  logic [63:0]           sized_value;

  logic                  out_valid;
  logic [63:0]           out_value;
  logic [1:0]            out_status;
  logic                  out_kept;

  assign step  = q_valid && (!out_valid || results.ready);
  assign q_pop = step;

  // saturate the width limit to what the counter holds
  assign width_load = ({16'd0, cfg.max_width} > WIDTH_CAP) ? WIDTH_CAP[WIDTH_BITS-1:0]
                                                          : WIDTH_BITS'(cfg.max_width);

  // Datapath: run the item through sign, prefix and digit phases
  always_comb begin
    field_phase   = phase;
    field_width   = width_left;
    field_accum   = accum;
    field_neg     = negative;
    field_matched = matched;
    field_base    = active_base;
    cont          = 1'b1;
    taken         = 1'b0;
    done          = 1'b0;
    width_hit     = 1'b0;
    digit_ok      = 1'b0;
    accum_upd     = accum;

    if (phase == PH_WS && !q_entry.eoi && !q_entry.is_ws) begin
      field_phase   = PH_SIGN;
      field_width   = width_load;
      field_accum   = '0;
      field_neg     = 1'b0;
      field_matched = 1'b0;
      field_base    = cfg.base_mode;
    end

    if (field_phase == PH_SIGN) begin
      field_phase = (field_base >= MODE_HEX) ? PH_PREFIX : PH_DIGITS;
      if (q_entry.is_minus) begin
        field_neg = 1'b1;
        taken     = 1'b1;
        cont      = 1'b0;
      end else if (q_entry.is_plus) begin
        taken = 1'b1;
        cont  = 1'b0;
      end
    end

    if (cont && field_phase == PH_PREFIX) begin
      if (q_entry.is_zero) begin
        field_phase = PH_AFTER0;
        taken       = 1'b1;
        cont        = 1'b0;
      end else begin
        if (field_base == MODE_AUTO) field_base = MODE_DEC;
        field_phase = PH_DIGITS;
      end
    end

    if (cont && field_phase == PH_AFTER0) begin
      field_phase = PH_DIGITS;
      if (q_entry.is_x) begin
        field_base = MODE_HEX;
        taken      = 1'b1;
        cont       = 1'b0;
      end else begin
        // a lone zero is already a match
        field_matched = 1'b1;
        if (field_base == MODE_AUTO) field_base = MODE_OCT;
      end
    end

    case (field_base)
      MODE_OCT: begin
        digit_ok  = q_entry.is_hex && (q_entry.digit < 4'd8);
        accum_upd = {field_accum[60:0], 3'b000} + 64'(q_entry.digit);
      end
      MODE_HEX: begin
        digit_ok  = q_entry.is_hex;
        accum_upd = {field_accum[59:0], 4'b0000} + 64'(q_entry.digit);
      end
      default: begin
        digit_ok  = q_entry.is_hex && (q_entry.digit < 4'd10);
        accum_upd = {field_accum[60:0], 3'b000} + {field_accum[62:0], 1'b0}
                    + 64'(q_entry.digit);
      end
    endcase

    if (cont && field_phase == PH_DIGITS) begin
      if (digit_ok) begin
        field_accum   = accum_upd;
        field_matched = 1'b1;
        taken         = 1'b1;
      end else begin
        done = 1'b1;
      end
    end

    if (taken && field_width != '0) begin
      field_width = field_width - 1'b1;
      if (field_width == '0) begin
        width_hit = 1'b1;
        if (field_phase == PH_AFTER0) field_matched = 1'b1;
      end
    end
  end

  // Outputs: decide whether this item closes the field
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_kept   = 1'b0;
    if (phase == PH_WS && q_entry.eoi) begin
      emit        = 1'b1;
      emit_status = ST_END_EARLY;
    end else if (field_phase != PH_WS && (q_entry.eoi || done || width_hit)) begin
      emit        = 1'b1;
      emit_status = field_matched ? ST_OK : ST_NO_MATCH;
      emit_kept   = done && !q_entry.eoi;
    end
  end

  assign signed_value = field_neg ? (64'd0 - field_accum) : field_accum;

  always_comb begin
    case (cfg.store_size)
      SIZE_8:  sized_value = {{56{signed_value[7]}},  signed_value[7:0]};
      SIZE_16: sized_value = {{48{signed_value[15]}}, signed_value[15:0]};
      SIZE_32: sized_value = {{32{signed_value[31]}}, signed_value[31:0]};
      default: sized_value = signed_value;
    endcase
  end

  // Next state: clear everything once a result goes out
  always_comb begin
    if (emit) begin
      phase_next       = PH_WS;
      width_left_next  = '0;
      accum_next       = '0;
      negative_next    = 1'b0;
      matched_next     = 1'b0;
      active_base_next = MODE_DEC;
    end else begin
      phase_next       = field_phase;
      width_left_next  = field_width;
      accum_next       = field_accum;
      negative_next    = field_neg;
      matched_next     = field_matched;
      active_base_next = field_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WS;
      width_left  <= '0;
      accum       <= '0;
      negative    <= 1'b0;
      matched     <= 1'b0;
      active_base <= MODE_DEC;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        phase       <= phase_next;
        width_left  <= width_left_next;
        accum       <= accum_next;
        negative    <= negative_next;
        matched     <= matched_next;
        active_base <= active_base_next;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_value  <= (emit_status == ST_OK) ? sized_value : 64'd0;
      out_status <= emit_status;
      out_kept   <= emit_kept;
    end
  end

  assign results.valid          = out_valid;
  assign results.value          = out_value;
  assign results.status         = out_status;
  assign results.stop_char_kept = out_kept;

  a_fail_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_value == 64'd0)
    else $error("failed field carries a non-zero value");

  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WS |-> accum == 64'd0 && !negative && !matched && active_base == MODE_DEC)
    else $error("field state left over while skipping whitespace");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == PH_WS && width_left == '0)
    else $error("field state not cleared after a result");

  a_kept_not_early: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kept |-> out_status != ST_END_EARLY)
    else $error("stop character flagged on an early end of input");

endmodule

@@ hw/rtl/integer_field_parser.sv @@
// Top level of the integer field parser: configuration registers and the
// front, queue and back end. Depends on ifp_pkg, ifp_if, ifp_front, ifp_queue, ifp_back.

// Reads one integer field per run from a character stream, in the manner of a
// scanf integer conversion: whitespace is skipped, an optional sign and, in hex
// or auto mode, a 0x or leading-zero prefix are taken, then digits are
// accumulated modulo 2^64 within the max_width limit. A result goes out when
// the field ends: on a non-digit (stop_char_kept set, that character is not
// consumed), on end of input or when the width limit runs out. Sustained rate
// is one character per clock while the result channel is not stalled; the back
// end then takes one queued item a cycle. Each character passes through a queue slot,
// and a field's result is registered in the output register. Configuration writes
// are taken at any time but belong between fields; base_mode and max_width are latched
// at the first character of a field, store_size is applied when the result is formed.
module integer_field_parser import ifp_pkg::*; #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  ifp_cfg_if.sink      cfg,
  ifp_char_if.sink     chars,
  ifp_result_if.source results
);

  cfg_t        cfg_regs;
  logic        q_push;
  logic        q_ready;
  char_class_t q_entry;
  logic        q_pop;
  logic        q_valid;
  char_class_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.base_mode  <= MODE_DEC;
      cfg_regs.max_width  <= '0;
      cfg_regs.store_size <= SIZE_32;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BASE_MODE:  cfg_regs.base_mode  <= cfg.data[1:0];
        REG_MAX_WIDTH:  cfg_regs.max_width  <= cfg.data;
        REG_STORE_SIZE: cfg_regs.store_size <= cfg.data[1:0];
        default:        ;
      endcase
    end
  end

  ifp_front u_front (
    .chars   (chars),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  ifp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_head)
  );

  ifp_back #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_entry (q_head),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

@@ dv/ifp_field_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard of the integer field parser: follows the configuration writes and the
// character items, predicts each field result and compares it with the result channel.
// Depends on ifp_pkg and the channel interfaces in ifp_if.
module ifp_field_checker import ifp_pkg::*; #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ifp_cfg_if          cfg,
  ifp_char_if         chars,
  ifp_result_if       results,
  output int unsigned mismatches,
  output int unsigned fields_pending,
  output int unsigned fields_checked
);

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic        kept;
  } field_result_t;

  field_result_t expected_fields[$];

  // Register copies
  logic [1:0]  base_mode_q  = MODE_DEC;
  logic [15:0] max_width_q  = '0;
  logic [1:0]  store_size_q = SIZE_32;

  // Parser state
  phase_t                phase       = PH_WS;
  logic [WIDTH_BITS-1:0] width_left  = '0;
  logic [63:0]           accum       = '0;
  logic                  negative    = 1'b0;
  logic                  matched     = 1'b0;
  logic [1:0]            active_base = MODE_DEC;

  int unsigned errs    = 0;
  int unsigned checked = 0;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] low;
    low = c | CH_LOWER_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
    if (low >= CH_LC_A && low <= CH_LC_F) return 5'(low - CH_LC_A + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [4:0] radix_for(input logic [1:0] b);
    if (b == MODE_OCT) return 5'd8;
    if (b == MODE_HEX) return 5'd16;
    return 5'd10;
  endfunction

  function automatic void clear_field();
    phase       = PH_WS;
    width_left  = '0;
    accum       = '0;
    negative    = 1'b0;
    matched     = 1'b0;
    active_base = MODE_DEC;
  endfunction

  // Walk the sign and prefix phases until the character is taken or the field ends.
  // Returns 1 when the character does not belong to the field.
  function automatic bit take_char(input bit present, input logic [7:0] c);
    bit         settled;
    bit         done;
    logic [4:0] d;
    logic [4:0] r;
    settled = 1'b0;
    done    = 1'b0;
    while (!settled) begin
      case (phase)
        PH_SIGN: begin
          if (active_base >= MODE_HEX) phase = PH_PREFIX;
          else phase = PH_DIGITS;
          if (present && c == CH_MINUS) begin
            negative = 1'b1;
            settled  = 1'b1;
          end else if (present && c == CH_PLUS) begin
            settled = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (present && c == CH_ZERO) begin
            phase   = PH_AFTER0;
            settled = 1'b1;
          end else begin
            if (active_base == MODE_AUTO) active_base = MODE_DEC;
            phase = PH_DIGITS;
          end
        end
        PH_AFTER0: begin
          phase = PH_DIGITS;
          if (present && (c | CH_LOWER_BIT) == CH_LC_X) begin
            active_base = MODE_HEX;
            settled     = 1'b1;
          end else begin
            // the zero itself already counts as a match
            matched = 1'b1;
            if (active_base == MODE_AUTO) active_base = MODE_OCT;
          end
        end
        default: begin
          d = present ? digit_value(c) : 5'd16;
          r = radix_for(active_base);
          if (d < r) begin
            accum   = accum * 64'(r) + 64'(d);
            matched = 1'b1;
          end else begin
            done = 1'b1;
          end
          settled = 1'b1;
        end
      endcase
    end
    return done;
  endfunction

  function automatic logic [63:0] stored_value();
    logic [63:0] v;
    v = negative ? (64'd0 - accum) : accum;
    case (store_size_q)
      SIZE_8:  v = {{56{v[7]}}, v[7:0]};
      SIZE_16: v = {{48{v[15]}}, v[15:0]};
      SIZE_32: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic void close_field(input logic [1:0] status, input logic kept);
    field_result_t f;
    f.value  = (status == ST_OK) ? stored_value() : 64'd0;
    f.status = status;
    f.kept   = kept;
    expected_fields.push_back(f);
    clear_field();
  endfunction

  function automatic logic [1:0] field_status();
    return matched ? ST_OK : ST_NO_MATCH;
  endfunction

  function automatic void predict_char(input logic eoi, input logic [7:0] c);
    logic [31:0] cap;
    cap = (32'd1 << WIDTH_BITS) - 32'd1;
    if (phase == PH_WS) begin
      if (eoi) begin
        close_field(ST_END_EARLY, 1'b0);
        return;
      end
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      accum       = '0;
      negative    = 1'b0;
      matched     = 1'b0;
      active_base = base_mode_q;
      width_left  = (32'(max_width_q) > cap) ? WIDTH_BITS'(cap) : WIDTH_BITS'(max_width_q);
      phase       = PH_SIGN;
    end
    if (eoi) begin
      void'(take_char(1'b0, c));
      close_field(field_status(), 1'b0);
      return;
    end
    if (take_char(1'b1, c)) begin
      close_field(field_status(), 1'b1);
      return;
    end
    if (width_left != '0) begin
      width_left = width_left - 1'b1;
      // width used up: close on this character, nothing kept
      if (width_left == '0) begin
        void'(take_char(1'b0, c));
        close_field(field_status(), 1'b0);
      end
    end
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (rst) begin
      base_mode_q  = MODE_DEC;
      max_width_q  = '0;
      store_size_q = SIZE_32;
      clear_field();
      expected_fields.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (expected_fields.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: value %h status %0d kept %0b", $time,
                   results.value, results.status, results.stop_char_kept);
        end else begin
          want = expected_fields.pop_front();
          checked++;
          if (results.value !== want.value) begin
            errs++;
            $display("%0t: value expected %h got %h", $time, want.value, results.value);
          end
          if (results.status !== want.status) begin
            errs++;
            $display("%0t: status expected %0d got %0d", $time, want.status, results.status);
          end
          if (results.stop_char_kept !== want.kept) begin
            errs++;
            $display("%0t: stop_char_kept expected %0b got %0b", $time, want.kept,
                     results.stop_char_kept);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BASE_MODE:  base_mode_q  = cfg.data[1:0];
          REG_MAX_WIDTH:  max_width_q  = cfg.data;
          REG_STORE_SIZE: store_size_q = cfg.data[1:0];
          default: ;
        endcase
      end
      if (chars.valid && chars.ready) predict_char(chars.cmd, chars.char_code);
    end
    mismatches     <= errs;
    fields_pending <= expected_fields.size();
    fields_checked <= checked;
  end

endmodule

@@ dv/tb_integer_field_parser.sv @@
`timescale 1ns / 1ps
// Top of the integer field parser testbench: clock, reset, character stimulus,
// result back-pressure, register writes and the verdict. Depends on ifp_pkg,
// ifp_if, the parser RTL and ifp_field_checker.
module tb_integer_field_parser import ifp_pkg::*; ();

  localparam int unsigned WIDTH_BITS   = 16;
  localparam int          HOLD_LEN     = 200;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASE_ITEMS  = 48;

  logic clk;
  logic rst;

  ifp_cfg_if    cfg();
  ifp_char_if   chars();
  ifp_result_if results();

  int unsigned mismatches;
  int unsigned fields_pending;
  int unsigned fields_checked;

  int unsigned items_sent    = 0;
  int unsigned settings_used = 1;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned idle_cycles   = 0;
  logic [1:0]  cur_base      = MODE_DEC;

  integer_field_parser #(.WIDTH_BITS(WIDTH_BITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .chars   (chars),
    .results (results)
  );

  ifp_field_checker #(.WIDTH_BITS(WIDTH_BITS)) field_check (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .chars          (chars),
    .results        (results),
    .mismatches     (mismatches),
    .fields_pending (fields_pending),
    .fields_checked (fields_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel in random spans; serve hold-off requests in full
  initial begin : receiver
    int mode;
    int span;
    mode = 0;
    span = 0;
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        results.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 150);
        end
        span--;
        case (mode)
          0: results.ready <= 1'b1;
          1: results.ready <= ($urandom_range(0, 3) != 0);
          2: results.ready <= ($urandom_range(0, 3) == 0);
          default: results.ready <= ~results.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("tb_integer_field_parser: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and hold it until taken; drop valid for a gap at the end of a burst
  task automatic send_item(input logic cmd, input logic [7:0] c);
    chars.valid     <= 1'b1;
    chars.cmd       <= cmd;
    chars.char_code <= c;
    do @(posedge clk); while (!chars.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 20);
      chars.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(1'b0, c);
  endtask

  task automatic send_end();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic pause_until_drained();
    chars.valid <= 1'b0;
    do @(posedge clk); while (fields_pending != 0);
  endtask

  task automatic settle();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic write_config(input logic [1:0] base, input logic [15:0] width,
                              input logic [1:0] size);
    write_reg(REG_BASE_MODE, 16'(base));
    write_reg(REG_MAX_WIDTH, width);
    write_reg(REG_STORE_SIZE, 16'(size));
    cfg.valid <= 1'b0;
    cur_base = base;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return CH_SPACE;
    return CH_TAB + 8'(k - 1);
  endfunction

  function automatic logic [7:0] pick_digit(input logic [1:0] b);
    int k;
    if (b == MODE_OCT) return CH_ZERO + 8'($urandom_range(0, 7));
    if (b == MODE_HEX) begin
      k = $urandom_range(0, 21);
      if (k < 10) return CH_ZERO + 8'(k);
      if (k < 16) return CH_LC_A + 8'(k - 10);
      return (CH_LC_A & ~CH_LOWER_BIT) + 8'(k - 16);
    end
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed fields with random content; the rest noise bytes and stray ends
  task automatic send_field();
    int         kind;
    int         n;
    logic [1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      send_char(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 15) begin
      send_end();
      return;
    end
    b = cur_base;
    repeat ($urandom_range(0, 2)) send_char(pick_space());
    case ($urandom_range(0, 3))
      0: send_char(CH_MINUS);
      1: send_char(CH_PLUS);
      default: ;
    endcase
    if (cur_base == MODE_HEX || cur_base == MODE_AUTO) begin
      case ($urandom_range(0, 3))
        0: begin
          send_char(CH_ZERO);
          send_char($urandom_range(0, 1) ? CH_LC_X : (CH_LC_X & ~CH_LOWER_BIT));
          b = MODE_HEX;
        end
        1: begin
          send_char(CH_ZERO);
          if (cur_base == MODE_AUTO) b = MODE_OCT;
        end
        default: if (cur_base == MODE_AUTO) b = MODE_DEC;
      endcase
    end
    // long runs now and then to wrap the accumulator
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 6);
    repeat (n) send_char(pick_digit(b));
    case ($urandom_range(0, 3))
      0: send_end();
      1: send_char(pick_space());
      default: send_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    bit          paused;
    rst             = 1'b1;
    chars.valid     = 1'b0;
    chars.cmd       = 1'b0;
    chars.char_code = '0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_BASE_MODE;
    cfg.data        = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: end before any field, negative number, lone sign
    send_end();
    send_text("\t-7,");
    send_text("+");
    send_end();

    // Hex, width 3, 8-bit store: lone zero, bare prefix, width used up
    settle();
    write_config(MODE_HEX, 16'd3, SIZE_8);
    send_char(CH_ZERO);
    send_char(8'h00);
    send_text("0xz");
    send_text("fFf");

    // Auto, unlimited, 64-bit store: octal after a zero, upper-case prefix
    settle();
    write_config(MODE_AUTO, 16'd0, SIZE_64);
    send_text("017");
    send_end();
    send_text("0X1");
    send_char(8'hFF);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: write_config(MODE_DEC, 16'd0, SIZE_64);
        1: write_config(MODE_OCT, 16'hFFFF, SIZE_8);
        2: write_config(MODE_HEX, 16'd1, SIZE_16);
        3: write_config(MODE_AUTO, 16'($urandom_range(2, 6)), SIZE_32);
        default: begin
          case ($urandom_range(0, 3))
            0: write_config(2'($urandom_range(0, 3)), 16'd0, 2'($urandom_range(0, 3)));
            1: write_config(2'($urandom_range(0, 3)), 16'($urandom_range(1, 8)),
                            2'($urandom_range(0, 3)));
            2: write_config(2'($urandom_range(0, 3)), 16'($urandom_range(9, 30)),
                            2'($urandom_range(0, 3)));
            default: write_config(2'($urandom_range(0, 3)), 16'($urandom),
                                  2'($urandom_range(0, 3)));
          endcase
        end
      endcase
      // hold the results back for a long stretch while items keep coming
      if (p == 4) hold_requests++;
      phase_start = items_sent;
      paused      = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_field();
        if (p == 5 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
          pause_until_drained();
          paused = 1'b1;
        end
      end
      send_end();
    end
    settle();

    $display("covered %0d character items under %0d register settings, %0d results compared",
             items_sent, settings_used, fields_checked);
    $display("directed edge cases plus random fields in every base mode and store size");
    if (mismatches == 0 && fields_pending == 0) begin
      $display("tb_integer_field_parser: clean");
    end else begin
      $display("tb_integer_field_parser: errors");
    end
    $finish;
  end

endmodule
